// ----- rtl/dual_key_sorted_queue_top_defines.svh -----
// Assertion macros shared by the dual key sorted queue RTL.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef DUAL_KEY_SORTED_QUEUE_TOP_DEFINES_SVH
`define DUAL_KEY_SORTED_QUEUE_TOP_DEFINES_SVH

// expr holds at every edge outside reset
`define DKSQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define DKSQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define DKSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dksq_pkg.sv -----
// Shared types and constants for the dual key sorted queue.
// No dependencies; used by every module of the block.
package dksq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W  = 16;
    localparam int SEQ_W = 16;
    localparam int PL_W  = 32;

    localparam int S_DATA_W = ID_W + SEQ_W + PL_W;
    localparam int S_USER_W = 2;

    localparam int M_RAW_W  = ID_W + SEQ_W + PL_W + ID_W + ID_W + CNT_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;
    localparam int M_USER_W = 2;

    // request buffer between front and back, power of two
    localparam int REQ_FIFO_DEPTH = 2;
    localparam int REQ_PTR_W      = $clog2(REQ_FIFO_DEPTH);
    localparam int REQ_CNT_W      = $clog2(REQ_FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_INS_ID  = 2'd0,
        REQ_INS_SEQ = 2'd1,
        REQ_APPEND  = 2'd2,
        REQ_POP     = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] seq;
        logic [PL_W-1:0]  payload;
    } entry_t;

    typedef struct packed {
        req_kind_t kind;
        entry_t    entry;
    } req_t;

    // compare result: ge[i] set where slot i is at or after the insert point
    typedef struct packed {
        logic [QUEUE_DEPTH-1:0] ge;
        logic                   at_end;
    } cmp_res_t;

    typedef struct packed {
        logic                   ins_en;
        logic                   pop_en;
        logic [QUEUE_DEPTH-1:0] ge;
    } cell_ctrl_t;

endpackage

// ----- rtl/dual_key_sorted_queue_top.sv -----
// Top level of the dual key sorted queue: front request buffer, entry cells,
// back sequencer and result register. Depends on dksq_pkg, dksq_front, dksq_cells.
//
// Usage:
//   s_ channel carries requests: s_tuser is the request kind (insert by id,
//   insert by sequence number, append, pop), s_tdata the entry to insert.
//   m_ channel returns one result beat per request: popped entry, head and
//   tail ids, entry count after the step, and in m_tuser the popped-valid
//   and rejected flags.
//   Each request passes through two back-end states: IDLE compares its key
//   at the FIFO head against all stored entries in parallel, EXEC shifts the
//   cells and loads the result register. A new request is taken from the
//   FIFO only after the previous one has left EXEC, so requests do not
//   overlap in the back end.
//   A two-entry request FIFO lets the sender keep going while a result
//   waits; if the receiver holds m_tready low, the back end waits in its
//   execute step with the cells untouched, and the FIFO fills, then
//   s_tready drops.
//   Reset (aresetn low, synchronous) empties the queue and both channels;
//   entry storage itself is not cleared, the count alone marks it valid.
`include "dual_key_sorted_queue_top_defines.svh"

module dual_key_sorted_queue_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] order_id, [31:16] seq_number, [63:32] payload
    input  logic [dksq_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [dksq_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] popped_id, [31:16] popped_seq, [63:32] popped_payload,
    // [79:64] head_id, [95:80] tail_id, [100:96] entry_count, rest zero
    output logic [dksq_pkg::M_DATA_W-1:0] m_tdata,
    // [0] popped_valid, [1] rejected
    output logic [dksq_pkg::M_USER_W-1:0] m_tuser
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    localparam int PAD_W = dksq_pkg::M_DATA_W - dksq_pkg::M_RAW_W;

    state_t                          state_reg;
    dksq_pkg::req_t                  req_reg;
    logic [dksq_pkg::QUEUE_DEPTH-1:0] ge_reg;
    logic                            at_end_reg;
    logic [dksq_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [dksq_pkg::ID_W-1:0]       tail_reg, tail_next;
    logic                            m_tvalid_reg;
    logic [dksq_pkg::M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [dksq_pkg::M_USER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                 fifo_valid;
    dksq_pkg::req_t       fifo_head;
    logic                 fifo_pop;
    dksq_pkg::cmp_res_t   cmp_res;
    dksq_pkg::cell_ctrl_t cell_ctrl;
    dksq_pkg::entry_t     slot0, slot1;

    logic                      out_free;
    logic                      exec_fire;
    logic                      is_pop;
    logic                      rej;
    logic                      popped_valid;
    dksq_pkg::entry_t          popped;
    logic [dksq_pkg::ID_W-1:0] head_id;
    logic [dksq_pkg::ID_W-1:0] tail_id;

    dksq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (fifo_valid),
        .req_head  (fifo_head),
        .req_pop   (fifo_pop)
    );

    // compare runs on the FIFO head in IDLE; result latched with the request
    dksq_cells u_cells (
        .aclk      (aclk),
        .cmp_req   (fifo_head),
        .count     (count_reg),
        .cmp_res   (cmp_res),
        .ctrl      (cell_ctrl),
        .new_entry (req_reg.entry),
        .slot0     (slot0),
        .slot1     (slot1)
    );

    assign fifo_pop  = (state_reg == ST_IDLE) && fifo_valid;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;
    assign is_pop    = (req_reg.kind == dksq_pkg::REQ_POP);
    assign rej       = is_pop ? (count_reg == '0)
                              : (count_reg == dksq_pkg::CNT_W'(dksq_pkg::QUEUE_DEPTH));

    assign cell_ctrl.ins_en = exec_fire && !is_pop && !rej;
    assign cell_ctrl.pop_en = exec_fire && is_pop && !rej;
    assign cell_ctrl.ge     = ge_reg;

    // result of the step, built from the pre-shift cells and the latched compare
    always_comb begin
        popped_valid = 1'b0;
        popped       = '0;
        count_next   = count_reg;
        tail_next    = tail_reg;
        head_id      = (count_reg != '0) ? slot0.id : '0;
        if (!rej) begin
            if (is_pop) begin
                popped_valid = 1'b1;
                popped       = slot0;
                count_next   = count_reg - 1'b1;
                head_id      = (count_reg > dksq_pkg::CNT_W'(1)) ? slot1.id : '0;
            end else begin
                count_next = count_reg + 1'b1;
                head_id    = ge_reg[0] ? req_reg.entry.id : slot0.id;
                if (at_end_reg) begin
                    tail_next = req_reg.entry.id;
                end
            end
        end
        tail_id      = (count_next != '0) ? tail_next : '0;
        m_tdata_next = {{PAD_W{1'b0}}, count_next, tail_id, head_id,
                        popped.payload, popped.seq, popped.id};
        m_tuser_next = {rej, popped_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !exec_fire) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (fifo_valid) begin
                        req_reg    <= fifo_head;
                        ge_reg     <= cmp_res.ge;
                        at_end_reg <= cmp_res.at_end;
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        count_reg    <= count_next;
                        tail_reg     <= tail_next;
                        m_tdata_reg  <= m_tdata_next;
                        m_tuser_reg  <= m_tuser_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `DKSQ_ASSERT_ALWAYS(a_count_bound, count_reg <= dksq_pkg::CNT_W'(dksq_pkg::QUEUE_DEPTH), "entry count above depth")
    `DKSQ_ASSERT_NEXT(a_pop_dec, cell_ctrl.pop_en, count_reg == $past(count_reg) - 1'b1, "pop did not decrement count")
    `DKSQ_ASSERT_NEXT(a_ins_inc, cell_ctrl.ins_en, count_reg == $past(count_reg) + 1'b1, "insert did not increment count")
    `DKSQ_ASSERT_IMPL(a_flags_excl, m_tvalid_reg, !(m_tuser_reg[0] && m_tuser_reg[1]), "popped and rejected together")

endmodule

// ----- rtl/dksq_front.sv -----
// Front end: takes request beats, decodes the kind, buffers them in a short FIFO.
// Depends on dksq_pkg and dual_key_sorted_queue_top_defines.svh.
`include "dual_key_sorted_queue_top_defines.svh"

module dksq_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] order_id, [31:16] seq_number, [63:32] payload
    input  logic [dksq_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [dksq_pkg::S_USER_W-1:0] s_tuser,
    output logic                          req_valid,
    output dksq_pkg::req_t                req_head,
    input  logic                          req_pop
);

    dksq_pkg::req_t                  fifo_mem_reg [dksq_pkg::REQ_FIFO_DEPTH];
    logic [dksq_pkg::REQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [dksq_pkg::REQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [dksq_pkg::REQ_CNT_W-1:0]  fill_reg, fill_next;
    dksq_pkg::req_t                  in_req;
    logic                            push;

    always_comb begin
        in_req.kind          = dksq_pkg::req_kind_t'(s_tuser[1:0]);
        in_req.entry.id      = s_tdata[dksq_pkg::ID_W-1:0];
        in_req.entry.seq     = s_tdata[dksq_pkg::ID_W +: dksq_pkg::SEQ_W];
        in_req.entry.payload = s_tdata[dksq_pkg::ID_W + dksq_pkg::SEQ_W +: dksq_pkg::PL_W];
    end

    assign s_tready  = (fill_reg != dksq_pkg::REQ_CNT_W'(dksq_pkg::REQ_FIFO_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign req_valid = (fill_reg != '0);
    assign req_head  = fifo_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = req_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + dksq_pkg::REQ_CNT_W'(push) - dksq_pkg::REQ_CNT_W'(req_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= in_req;
        end
    end

    `DKSQ_ASSERT_IMPL(a_front_pop_nonempty, req_pop, fill_reg != '0, "pop from empty request fifo")
    `DKSQ_ASSERT_ALWAYS(a_front_fill_bound, fill_reg <= dksq_pkg::REQ_CNT_W'(dksq_pkg::REQ_FIFO_DEPTH), "request fifo overfilled")

endmodule

// ----- rtl/dksq_cells.sv -----
// Entry cells of the queue: parallel key compare and one-step shift in or out.
// Depends on dksq_pkg.
module dksq_cells (
    input  logic                       aclk,
    input  dksq_pkg::req_t             cmp_req,
    input  logic [dksq_pkg::CNT_W-1:0] count,
    output dksq_pkg::cmp_res_t         cmp_res,
    input  dksq_pkg::cell_ctrl_t       ctrl,
    input  dksq_pkg::entry_t           new_entry,
    output dksq_pkg::entry_t           slot0,
    output dksq_pkg::entry_t           slot1
);

    localparam int D = dksq_pkg::QUEUE_DEPTH;

    dksq_pkg::entry_t slot_reg [D];
    logic [D-1:0]     sort_hit;
    logic [D-1:0]     hit;
    logic             sorted;
    logic             by_seq;

    assign sorted = (cmp_req.kind == dksq_pkg::REQ_INS_ID) ||
                    (cmp_req.kind == dksq_pkg::REQ_INS_SEQ);
    assign by_seq = (cmp_req.kind == dksq_pkg::REQ_INS_SEQ);

    // first slot whose key is strictly greater, else the slot just past the end
    always_comb begin
        for (int i = 0; i < D; i++) begin
            sort_hit[i] = sorted && (dksq_pkg::CNT_W'(i) < count) &&
                          (by_seq ? (cmp_req.entry.seq < slot_reg[i].seq)
                                  : (cmp_req.entry.id < slot_reg[i].id));
            hit[i]      = sort_hit[i] || (dksq_pkg::CNT_W'(i) == count);
        end
        for (int i = 0; i < D; i++) begin
            cmp_res.ge[i] = |(hit & ({D{1'b1}} >> (D - 1 - i)));
        end
        cmp_res.at_end = ~|sort_hit;
    end

    for (genvar g = 0; g < D; g++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (ctrl.pop_en) begin
                if (g < D - 1) begin
                    slot_reg[g] <= slot_reg[(g + 1) % D];
                end
            end else if (ctrl.ins_en && ctrl.ge[g]) begin
                if (g == 0) begin
                    slot_reg[g] <= new_entry;
                end else begin
                    slot_reg[g] <= ctrl.ge[(g + D - 1) % D] ? slot_reg[(g + D - 1) % D]
                                                            : new_entry;
                end
            end
        end
    end

    assign slot0 = slot_reg[0];
    assign slot1 = slot_reg[1];

endmodule

// ----- sim/dual_key_sorted_queue_top_tb.sv -----
// Testbench for dual_key_sorted_queue_top: directed table then random requests,
// each result beat checked against a typed row's result or a model of the ordered queue.
// Depends on dksq_pkg and the dual_key_sorted_queue_top RTL.
`timescale 1ns / 1ps

module dual_key_sorted_queue_top_tb;

    // one result beat, field by field
    typedef struct {
        logic                       pop_ok;
        logic [dksq_pkg::ID_W-1:0]  pop_id;
        logic [dksq_pkg::SEQ_W-1:0] pop_seq;
        logic [dksq_pkg::PL_W-1:0]  pop_pl;
        logic [dksq_pkg::ID_W-1:0]  head;
        logic [dksq_pkg::ID_W-1:0]  tail;
        logic [dksq_pkg::CNT_W-1:0] count;
        logic                       rej;
    } queue_status_t;

    // directed step; typed rows carry a hand-written result
    typedef struct {
        dksq_pkg::req_kind_t        kind;
        logic [dksq_pkg::ID_W-1:0]  id;
        logic [dksq_pkg::SEQ_W-1:0] seq;
        logic [dksq_pkg::PL_W-1:0]  pl;
        bit                         typed;
        queue_status_t              want;
    } queue_step_t;

    localparam int PHASE_ITEMS = 584;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [dksq_pkg::S_DATA_W-1:0]   s_tdata;
    logic [dksq_pkg::S_USER_W-1:0]   s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [dksq_pkg::M_DATA_W-1:0]   m_tdata;
    logic [dksq_pkg::M_USER_W-1:0]   m_tuser;

    // shadow of the queue contents, head at index 0
    dksq_pkg::entry_t held_entries[dksq_pkg::QUEUE_DEPTH];
    int               held_count;
    queue_status_t    due_status[$];
    queue_step_t      directed_steps[$];

    int mismatches;
    int beats_seen;
    int src_idle_pct;
    int snk_idle_pct;

    dual_key_sorted_queue_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Applies one request to the shadow queue and returns the status it yields.
    // Sorted inserts land before the first strictly greater key (stable on ties).
    function automatic queue_status_t next_queue_status(dksq_pkg::req_kind_t kind,
                                                        dksq_pkg::entry_t ent);
        queue_status_t st;
        int            pos;
        int            i;
        bit            found;
        st.pop_ok  = 1'b0;
        st.pop_id  = '0;
        st.pop_seq = '0;
        st.pop_pl  = '0;
        st.rej     = 1'b0;
        if (kind == dksq_pkg::REQ_POP) begin
            if (held_count == 0) begin
                st.rej = 1'b1;
            end else begin
                st.pop_ok  = 1'b1;
                st.pop_id  = held_entries[0].id;
                st.pop_seq = held_entries[0].seq;
                st.pop_pl  = held_entries[0].payload;
                for (i = 1; i < held_count; i++)
                    held_entries[i-1] = held_entries[i];
                held_count--;
            end
        end else if (held_count >= dksq_pkg::QUEUE_DEPTH) begin
            st.rej = 1'b1;
        end else begin
            pos   = held_count;
            found = 1'b0;
            for (i = 0; i < held_count; i++) begin
                if (!found && ((kind == dksq_pkg::REQ_INS_ID &&
                                ent.id < held_entries[i].id) ||
                               (kind == dksq_pkg::REQ_INS_SEQ &&
                                ent.seq < held_entries[i].seq))) begin
                    pos   = i;
                    found = 1'b1;
                end
            end
            for (i = held_count; i > pos; i--)
                held_entries[i] = held_entries[i-1];
            held_entries[pos] = ent;
            held_count++;
        end
        st.head  = (held_count != 0) ? held_entries[0].id : '0;
        st.tail  = (held_count != 0) ? held_entries[held_count-1].id : '0;
        st.count = dksq_pkg::CNT_W'(held_count);
        return st;
    endfunction

    function automatic queue_step_t plain_step(dksq_pkg::req_kind_t kind,
                                               logic [dksq_pkg::ID_W-1:0] id,
                                               logic [dksq_pkg::SEQ_W-1:0] seq,
                                               logic [dksq_pkg::PL_W-1:0] pl);
        queue_step_t s;
        s.kind  = kind;
        s.id    = id;
        s.seq   = seq;
        s.pl    = pl;
        s.typed = 1'b0;
        return s;
    endfunction

    function automatic queue_step_t typed_step(queue_step_t s, logic pop_ok,
                                               logic [dksq_pkg::ID_W-1:0] pop_id,
                                               logic [dksq_pkg::SEQ_W-1:0] pop_seq,
                                               logic [dksq_pkg::PL_W-1:0] pop_pl,
                                               logic [dksq_pkg::ID_W-1:0] head,
                                               logic [dksq_pkg::ID_W-1:0] tail,
                                               int count, logic rej);
        s.typed        = 1'b1;
        s.want.pop_ok  = pop_ok;
        s.want.pop_id  = pop_id;
        s.want.pop_seq = pop_seq;
        s.want.pop_pl  = pop_pl;
        s.want.head    = head;
        s.want.tail    = tail;
        s.want.count   = dksq_pkg::CNT_W'(count);
        s.want.rej     = rej;
        return s;
    endfunction

    // random keys half the time, else a small pool for ties or the two extremes
    function automatic logic [15:0] pick_key();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(7));
            1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns beat %0d: %s got %0h want %0h", $time, beats_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_status();
        queue_status_t want;
        if (due_status.size() == 0) begin
            report_mismatch("result beat with nothing due", m_tdata[31:0], 32'd0);
            return;
        end
        want = due_status.pop_front();
        if (m_tuser[0] !== want.pop_ok)
            report_mismatch("popped_valid", 32'(m_tuser[0]), 32'(want.pop_ok));
        if (m_tdata[15:0] !== want.pop_id)
            report_mismatch("popped_id", 32'(m_tdata[15:0]), 32'(want.pop_id));
        if (m_tdata[31:16] !== want.pop_seq)
            report_mismatch("popped_seq", 32'(m_tdata[31:16]), 32'(want.pop_seq));
        if (m_tdata[63:32] !== want.pop_pl)
            report_mismatch("popped_payload", m_tdata[63:32], want.pop_pl);
        if (m_tdata[79:64] !== want.head)
            report_mismatch("head_id", 32'(m_tdata[79:64]), 32'(want.head));
        if (m_tdata[95:80] !== want.tail)
            report_mismatch("tail_id", 32'(m_tdata[95:80]), 32'(want.tail));
        if (m_tdata[100:96] !== want.count)
            report_mismatch("entry_count", 32'(m_tdata[100:96]), 32'(want.count));
        if (m_tuser[1] !== want.rej)
            report_mismatch("rejected", 32'(m_tuser[1]), 32'(want.rej));
    endtask

    // receiver: ready toggles at the falling edge, beats checked at the rising one
    always @(negedge aclk)
        m_tready = ($urandom_range(99) >= snk_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_status();
            beats_seen++;
        end
    end

    // Sends one request beat. Entered and left at a falling edge; valid stays
    // high on exit so back-to-back beats need no second assignment.
    task automatic send_request(queue_step_t s);
        dksq_pkg::entry_t ent;
        queue_status_t    got;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = s.kind;
        s_tdata  = {s.pl, s.seq, s.id};
        do @(posedge aclk); while (!s_tready);
        ent.id      = s.id;
        ent.seq     = s.seq;
        ent.payload = s.pl;
        got = next_queue_status(s.kind, ent);
        due_status.push_back(s.typed ? s.want : got);
        @(negedge aclk);
    endtask

    // sender holds off until every due result has come back
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (due_status.size() != 0)
            @(negedge aclk);
    endtask

    // Random requests: the pop share drifts every 32 beats so the queue keeps
    // swinging between empty and full; a drain sits in the middle.
    task automatic random_phase(int n_items);
        queue_step_t s;
        int          n;
        int          pop_pct;
        for (n = 0; n < n_items; n++) begin
            if (n % 32 == 0)
                pop_pct = ($urandom_range(2) == 0) ? 20 : ($urandom_range(1) ? 80 : 50);
            if (n == n_items / 2)
                drain_results();
            s = plain_step(dksq_pkg::REQ_POP, pick_key(), pick_key(), 32'($urandom));
            if ($urandom_range(99) >= pop_pct)
                s.kind = dksq_pkg::req_kind_t'($urandom_range(2));
            send_request(s);
        end
    endtask

    initial begin
        int k;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = dksq_pkg::REQ_INS_ID;
        m_tready     = 1'b0;
        held_count   = 0;
        mismatches   = 0;
        beats_seen   = 0;
        src_idle_pct = 22;
        snk_idle_pct = 59;

        // Directed table. Typed rows: pop on empty, the first inserts, the
        // rejects on a full queue and the pop of the zero-id entry.
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_POP, 16'h0, 16'h0, 32'h0),
            1'b0, 16'h0, 16'h0, 32'h0, 16'h0000, 16'h0000, 0, 1'b1));
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_INS_ID, 16'h8000, 16'h0001, 32'h0000_0000),
            1'b0, 16'h0, 16'h0, 32'h0, 16'h8000, 16'h8000, 1, 1'b0));
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_INS_ID, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF),
            1'b0, 16'h0, 16'h0, 32'h0, 16'h0000, 16'h8000, 2, 1'b0));
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_INS_ID, 16'hFFFF, 16'h0000, 32'hA5A5_A5A5),
            1'b0, 16'h0, 16'h0, 32'h0, 16'h0000, 16'hFFFF, 3, 1'b0));
        // equal id goes behind the stored one
        directed_steps.push_back(plain_step(dksq_pkg::REQ_INS_ID, 16'h8000, 16'h0002,
                                            32'h0000_0001));
        directed_steps.push_back(plain_step(dksq_pkg::REQ_INS_SEQ, 16'h1234, 16'h0000,
                                            32'h5A5A_5A5A));
        directed_steps.push_back(plain_step(dksq_pkg::REQ_INS_SEQ, 16'h4321, 16'hFFFF,
                                            32'h8000_0000));
        directed_steps.push_back(plain_step(dksq_pkg::REQ_APPEND, 16'h7777, 16'h1111,
                                            32'h7FFF_FFFF));
        directed_steps.push_back(plain_step(dksq_pkg::REQ_POP, 16'h0, 16'h0, 32'h0));
        // six held, ten appends fill it
        for (k = 0; k < 10; k++)
            directed_steps.push_back(plain_step(dksq_pkg::REQ_APPEND, 16'hA000 + 16'(k),
                                                16'(k * 16'h1357), 32'(k * 32'h1111_1111)));
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_INS_ID, 16'h0, 16'h0, 32'h0),
            1'b0, 16'h0, 16'h0, 32'h0, 16'h0000, 16'hA009, 16, 1'b1));
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_INS_SEQ, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF),
            1'b0, 16'h0, 16'h0, 32'h0, 16'h0000, 16'hA009, 16, 1'b1));
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_APPEND, 16'h1111, 16'h2222, 32'h3333_3333),
            1'b0, 16'h0, 16'h0, 32'h0, 16'h0000, 16'hA009, 16, 1'b1));
        directed_steps.push_back(typed_step(
            plain_step(dksq_pkg::REQ_POP, 16'h0, 16'h0, 32'h0),
            1'b1, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 16'h8000, 16'hA009, 15, 1'b0));
        directed_steps.push_back(plain_step(dksq_pkg::REQ_INS_SEQ, 16'h5555, 16'h0000,
                                            32'h1234_5678));
        directed_steps.push_back(plain_step(dksq_pkg::REQ_POP, 16'h0, 16'h0, 32'h0));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_steps[i])
            send_request(directed_steps[i]);

        random_phase(PHASE_ITEMS);
        drain_results();
        src_idle_pct = 59;
        snk_idle_pct = 22;
        random_phase(PHASE_ITEMS);
        drain_results();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(PHASE_ITEMS);
        drain_results();

        // allow a stray late beat to show up
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
